/* hw/rtl/svrw_pkg.sv */
// svrw_pkg: constants, types and helper functions of the voxel ray walk unit
// no dependencies; imported by svrw_front, svrw_queue, svrw_back and the top level
package svrw_pkg;

	localparam int GRID_X      = 32;
	localparam int GRID_Y      = 32;
	localparam int GRID_Z      = 16;
	localparam int COUNT_WIDTH = 16;

	localparam int XW    = $clog2(GRID_X);
	localparam int YW    = $clog2(GRID_Y);
	localparam int ZW    = $clog2(GRID_Z);
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;
	localparam int TW    = 10;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [2:0] CFG_GMIN_X = 3'd0;
	localparam logic [2:0] CFG_GMIN_Y = 3'd1;
	localparam logic [2:0] CFG_GMIN_Z = 3'd2;
	localparam logic [2:0] CFG_SIZE_X = 3'd3;
	localparam logic [2:0] CFG_SIZE_Y = 3'd4;
	localparam logic [2:0] CFG_SIZE_Z = 3'd5;
	localparam logic [2:0] CFG_SEED   = 3'd6;

	localparam logic CMD_CAST = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [ZW-1:0] z;
	} vox_t;

	typedef struct packed {
		logic cmd;
		vox_t pt;
		vox_t tg;
	} entry_t;

	typedef struct packed {
		logic signed [15:0] gmin_x;
		logic signed [15:0] gmin_y;
		logic signed [15:0] gmin_z;
		logic [8:0]         top_x;
		logic [8:0]         top_y;
		logic [8:0]         top_z;
	} grid_cfg_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
		logic   full;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_PICK, ST_MRD, ST_MWR, ST_HRD, ST_HWR, ST_OUT
	} walk_state_t;

	// highest usable index from a size register
	function automatic logic [8:0] eff_top(logic [5:0] s, int grid);
		logic [8:0] r;
		if (s == 6'd0) r = 9'd0;
		else if ({3'b000, s} > 9'(grid)) r = 9'(grid - 1);
		else r = {3'b000, s} - 9'd1;
		return r;
	endfunction

	// nearest voxel, ties to the lower one, clamped
	function automatic logic [8:0] snap_idx(logic signed [15:0] p, logic signed [15:0] gmin,
		logic [8:0] top);
		logic signed [17:0] d;
		logic [14:0]        idx;
		logic [8:0]         r;
		d   = 18'(p) - 18'(gmin) + 18'sd3;
		idx = 15'(d[17:3]);
		if (d[17]) r = 9'd0;
		else if (idx > {6'd0, top}) r = top;
		else r = idx[8:0];
		return r;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

/* hw/rtl/svrw_if.sv */
// svrw_if: valid/ready channel interfaces for cast/read items and results
// depends on nothing
interface svrw_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [15:0] sensor_x;
	logic signed [15:0] sensor_y;
	logic signed [15:0] sensor_z;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] point_z;
	logic [4:0]         query_x;
	logic [4:0]         query_y;
	logic [3:0]         query_z;

	modport source (output valid, cmd, sensor_x, sensor_y, sensor_z, point_x, point_y,
		point_z, query_x, query_y, query_z, input ready);
	modport sink (input valid, cmd, sensor_x, sensor_y, sensor_z, point_x, point_y,
		point_z, query_x, query_y, query_z, output ready);
endinterface

interface svrw_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [4:0]  voxel_x;
	logic [4:0]  voxel_y;
	logic [3:0]  voxel_z;
	logic [15:0] hit_count;
	logic [15:0] miss_count;
	logic [6:0]  steps_taken;

	modport source (output valid, kind, voxel_x, voxel_y, voxel_z, hit_count, miss_count,
		steps_taken, input ready);
	modport sink (input valid, kind, voxel_x, voxel_y, voxel_z, hit_count, miss_count,
		steps_taken, output ready);
endinterface

/* hw/rtl/svrw_front.sv */
// svrw_front: accepts items, snaps cast points to voxels, clamps read queries
// depends on svrw_pkg and svrw_if
module svrw_front import svrw_pkg::*; (
	svrw_in_if.sink   in_ch,
	input  grid_cfg_t gcfg,
	input  logic      clr_busy,
	input  logic      q_full,
	output logic      push,
	output entry_t    push_data
);

	logic [8:0] qx, qy, qz;

	assign in_ch.ready = !q_full && !clr_busy;
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		qx = ({4'd0, in_ch.query_x} > 9'(GRID_X - 1)) ? 9'(GRID_X - 1) : {4'd0, in_ch.query_x};
		qy = ({4'd0, in_ch.query_y} > 9'(GRID_Y - 1)) ? 9'(GRID_Y - 1) : {4'd0, in_ch.query_y};
		qz = ({5'd0, in_ch.query_z} > 9'(GRID_Z - 1)) ? 9'(GRID_Z - 1) : {5'd0, in_ch.query_z};
		push_data.cmd = in_ch.cmd;
		push_data.pt.x = XW'(snap_idx(in_ch.sensor_x, gcfg.gmin_x, gcfg.top_x));
		push_data.pt.y = YW'(snap_idx(in_ch.sensor_y, gcfg.gmin_y, gcfg.top_y));
		push_data.pt.z = ZW'(snap_idx(in_ch.sensor_z, gcfg.gmin_z, gcfg.top_z));
		if (in_ch.cmd == CMD_READ) begin
			push_data.tg.x = XW'(qx);
			push_data.tg.y = YW'(qy);
			push_data.tg.z = ZW'(qz);
		end else begin
			push_data.tg.x = XW'(snap_idx(in_ch.point_x, gcfg.gmin_x, gcfg.top_x));
			push_data.tg.y = YW'(snap_idx(in_ch.point_y, gcfg.gmin_y, gcfg.top_y));
			push_data.tg.z = ZW'(snap_idx(in_ch.point_z, gcfg.gmin_z, gcfg.top_z));
		end
	end

endmodule

/* hw/rtl/svrw_queue.sv */
// svrw_queue: two-entry queue between front and walk engine
// depends on svrw_pkg
module svrw_queue import svrw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_data,
	input  logic    pop,
	output q_stat_t stat
);

	entry_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	assign stat.valid = cnt_q != 2'd0;
	assign stat.full  = cnt_q == 2'd2;
	assign stat.data  = mem_q[rp_q];

endmodule

/* hw/rtl/svrw_back.sv */
// svrw_back: walk engine with lfsr axis choice and hit/miss counter memories
// depends on svrw_pkg and svrw_if
module svrw_back import svrw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   stat,
	output logic      pop,
	input  logic      seed_wr,
	input  logic [15:0] seed,
	output logic      clr_busy,
	svrw_out_if.source out_ch
);

	walk_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] hit_mem  [DEPTH];
	logic [COUNT_WIDTH-1:0] miss_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] hit_rd_q, miss_rd_q;

	logic [15:0]   lfsr_q, lfsr_nx;
	vox_t          pt_q, tg_q, pt_nx;
	logic [XW-1:0] wx_q;
	logic [YW-1:0] wy_q;
	logic [ZW-1:0] wz_q;
	logic [TW-1:0] tot_q;
	logic [6:0]    steps_q;
	logic          kind_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] rd_a;

	logic [TW+15:0] prod;
	logic [TW-1:0]  v;
	logic [1:0]     ax;
	logic           ax_done;
	logic [XW-1:0]  ewx;
	logic [YW-1:0]  ewy;
	logic [ZW-1:0]  ewz;

	logic [COUNT_WIDTH-1:0] res_hit_q, res_miss_q;

	always_comb begin
		lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);
		prod    = 26'(lfsr_nx) * 26'(tot_q);
		v       = prod[TW+15:16];
		if (v < TW'(wx_q)) ax = 2'd0;
		else if (v < TW'(wx_q) + TW'(wy_q)) ax = 2'd1;
		else ax = 2'd2;
		pt_nx = pt_q;
		case (ax)
			2'd0: begin
				ax_done = pt_q.x == tg_q.x;
				pt_nx.x = (pt_q.x < tg_q.x) ? pt_q.x + 1'b1 : pt_q.x - 1'b1;
			end
			2'd1: begin
				ax_done = pt_q.y == tg_q.y;
				pt_nx.y = (pt_q.y < tg_q.y) ? pt_q.y + 1'b1 : pt_q.y - 1'b1;
			end
			default: begin
				ax_done = pt_q.z == tg_q.z;
				pt_nx.z = (pt_q.z < tg_q.z) ? pt_q.z + 1'b1 : pt_q.z - 1'b1;
			end
		endcase
		ewx = (stat.data.pt.x > stat.data.tg.x) ? stat.data.pt.x - stat.data.tg.x
			: stat.data.tg.x - stat.data.pt.x;
		ewy = (stat.data.pt.y > stat.data.tg.y) ? stat.data.pt.y - stat.data.tg.y
			: stat.data.tg.y - stat.data.pt.y;
		ewz = (stat.data.pt.z > stat.data.tg.z) ? stat.data.pt.z - stat.data.tg.z
			: stat.data.tg.z - stat.data.pt.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (stat.valid) begin
					pop = 1'b1;
					if (stat.data.cmd == CMD_READ || stat.data.pt == stat.data.tg)
						state_d = ST_HRD;
					else
						state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (!ax_done) state_d = (pt_nx == tg_q) ? ST_HRD : ST_MRD;
			end
			ST_MRD:  state_d = ST_MWR;
			ST_MWR:  state_d = ST_PICK;
			ST_HRD:  state_d = ST_HWR;
			ST_HWR:  state_d = ST_OUT;
			ST_OUT:  if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_a     = (state_q == ST_MRD) ? pt_q : tg_q;
	assign clr_busy = state_q == ST_CLEAR;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			hit_mem[clr_q]  <= '0;
			miss_mem[clr_q] <= '0;
		end else begin
			if (state_q == ST_MWR) miss_mem[pt_q] <= sat_inc(miss_rd_q);
			if (state_q == ST_HWR && kind_q == CMD_CAST) hit_mem[tg_q] <= sat_inc(hit_rd_q);
		end
		hit_rd_q  <= hit_mem[rd_a];
		miss_rd_q <= miss_mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= 16'd1;
			clr_q   <= '0;
			steps_q <= '0;
			kind_q  <= CMD_CAST;
			pt_q    <= '0;
			tg_q    <= '0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (seed_wr) lfsr_q <= (seed == 16'd0) ? 16'd1 : seed;
			else if (state_q == ST_PICK) lfsr_q <= lfsr_nx;
			if (state_q == ST_IDLE && stat.valid) begin
				pt_q    <= stat.data.pt;
				tg_q    <= stat.data.tg;
				kind_q  <= stat.data.cmd;
				steps_q <= '0;
			end else if (state_q == ST_PICK && !ax_done) begin
				pt_q    <= pt_nx;
				steps_q <= (steps_q == 7'd127) ? steps_q : steps_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && stat.valid) begin
			wx_q  <= ewx;
			wy_q  <= ewy;
			wz_q  <= ewz;
			tot_q <= TW'(ewx) + TW'(ewy) + TW'(ewz);
		end
		if (state_q == ST_HWR) begin
			res_hit_q  <= (kind_q == CMD_CAST) ? sat_inc(hit_rd_q) : hit_rd_q;
			res_miss_q <= miss_rd_q;
		end
	end

	assign out_ch.valid       = state_q == ST_OUT;
	assign out_ch.kind        = kind_q;
	assign out_ch.voxel_x     = 5'(tg_q.x);
	assign out_ch.voxel_y     = 5'(tg_q.y);
	assign out_ch.voxel_z     = 4'(tg_q.z);
	assign out_ch.hit_count   = 16'(res_hit_q);
	assign out_ch.miss_count  = 16'(res_miss_q);
	assign out_ch.steps_taken = (kind_q == CMD_READ) ? 7'd0 : steps_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !pop)
		else $error("queue popped during clearing pass");
	a_hit_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HRD && kind_q == CMD_CAST) |-> pt_q == tg_q)
		else $error("hit counted before the walk reached the endpoint");
	a_hwr_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HWR |=> out_ch.valid)
		else $error("result not presented after counter update");
	a_miss_off_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MWR |-> pt_q != tg_q)
		else $error("miss counted on the endpoint");

endmodule

/* hw/rtl/stochastic_voxel_ray_walk_unit.sv */
// stochastic_voxel_ray_walk_unit: top level, configuration registers and wiring
// depends on svrw_pkg, svrw_if, svrw_front, svrw_queue, svrw_back
// engine idle: a read goes via ST_IDLE, ST_HRD and ST_HWR to ST_OUT; a cast also passes
//   ST_PICK per lfsr pick (retries included) and ST_MRD, ST_MWR per miss voxel
// throughput: one item at a time in the walk engine, set by its per-step memory
//   read-modify-write; the two-entry queue lets the front take items meanwhile
// reset: a clearing pass over all 16384 addresses zeroes both counter memories; no
//   item is taken during it, configuration writes are taken as ever
module stochastic_voxel_ray_walk_unit import svrw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	svrw_in_if.sink     in_ch,
	svrw_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic signed [15:0] gmin_x_q, gmin_y_q, gmin_z_q;
	logic [5:0]         size_x_q, size_y_q;
	logic [4:0]         size_z_q;

	grid_cfg_t gcfg;
	q_stat_t   stat;
	entry_t    push_data;
	logic      push, pop, clr_busy, seed_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmin_x_q <= '0;
			gmin_y_q <= '0;
			gmin_z_q <= '0;
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GMIN_X: gmin_x_q <= cfg_data;
				CFG_GMIN_Y: gmin_y_q <= cfg_data;
				CFG_GMIN_Z: gmin_z_q <= cfg_data;
				CFG_SIZE_X: size_x_q <= cfg_data[5:0];
				CFG_SIZE_Y: size_y_q <= cfg_data[5:0];
				CFG_SIZE_Z: size_z_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// seed goes straight into the walk engine's lfsr
	assign seed_wr = cfg_we && cfg_index == CFG_SEED;

	// effective clamping limits per axis
	assign gcfg.gmin_x = gmin_x_q;
	assign gcfg.gmin_y = gmin_y_q;
	assign gcfg.gmin_z = gmin_z_q;
	assign gcfg.top_x  = eff_top(size_x_q, GRID_X);
	assign gcfg.top_y  = eff_top(size_y_q, GRID_Y);
	assign gcfg.top_z  = eff_top({1'b0, size_z_q}, GRID_Z);

	svrw_front u_front (
		.in_ch     (in_ch),
		.gcfg      (gcfg),
		.clr_busy  (clr_busy),
		.q_full    (stat.full),
		.push      (push),
		.push_data (push_data)
	);

	svrw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.stat      (stat)
	);

	svrw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.pop      (pop),
		.seed_wr  (seed_wr),
		.seed     (cfg_data),
		.clr_busy (clr_busy),
		.out_ch   (out_ch)
	);

endmodule
